// ----- rtl/core/gbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// gbsd_pkg
// Shared types, widths and codes for the graph bond store / degree tracker.
// ----------------------------------------------------------------------------
package gbsd_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VNUM_W       = 4;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int DEG_W        = 3;
  localparam int CNT_W        = 4;
  localparam int BOND_W       = 5;
  localparam int KEY_W        = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int PAIR_W       = $clog2(KEY_W + 1);
  localparam int PROD_W       = 2 * VNUM_W;

  localparam logic [VNUM_W-1:0] VCOUNT_RESET = VNUM_W'(MAX_VERTICES);
  localparam logic [VNUM_W-1:0] VCOUNT_MIN   = VNUM_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD,
    FN_REMOVE,
    FN_CLEAR,
    FN_NOP
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_SAME,
    ST_RANGE,
    ST_PRESENT,
    ST_ABSENT
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_WALK,
    S_REPORT
  } state_t;

  // row i, bit j: vertices i+1 and j+1 are bonded
  typedef logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] adj_t;

  typedef struct packed {
    logic              apply;
    func_t             func;
    logic [VNUM_W-1:0] vertex_a;
    logic [VNUM_W-1:0] vertex_b;
  } store_ctl_t;

  typedef struct packed {
    status_t           status;
    logic [BOND_W-1:0] bond_count;
    logic [DEG_W-1:0]  degree_a;
    logic [DEG_W-1:0]  degree_b;
    logic [CNT_W-1:0]  count_at_degree_a;
    logic [CNT_W-1:0]  count_at_degree_b;
    logic [KEY_W-1:0]  graph_key;
    logic [VNUM_W-1:0] last_vertex;
  } report_t;

endpackage

// ----- rtl/core/gbsd_cmd_if.sv -----
// ----------------------------------------------------------------------------
// gbsd_cmd_if
// Command channel: one word is a bond operation and its two vertices.
// ----------------------------------------------------------------------------
interface gbsd_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [gbsd_pkg::FUNC_W-1:0] func;
  logic [gbsd_pkg::VNUM_W-1:0] vertex_a;
  logic [gbsd_pkg::VNUM_W-1:0] vertex_b;

  modport source (output valid, output func, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input func, input vertex_a, input vertex_b, output ready);
endinterface

// ----- rtl/core/gbsd_rpt_if.sv -----
// ----------------------------------------------------------------------------
// gbsd_rpt_if
// Report channel: one word per command with status, counts, key and reach.
// ----------------------------------------------------------------------------
interface gbsd_rpt_if;
  logic                          valid;
  logic                          ready;
  logic [gbsd_pkg::STATUS_W-1:0] status;
  logic [gbsd_pkg::BOND_W-1:0]   bond_count;
  logic [gbsd_pkg::DEG_W-1:0]    degree_a;
  logic [gbsd_pkg::DEG_W-1:0]    degree_b;
  logic [gbsd_pkg::CNT_W-1:0]    count_at_degree_a;
  logic [gbsd_pkg::CNT_W-1:0]    count_at_degree_b;
  logic [gbsd_pkg::KEY_W-1:0]    graph_key;
  logic [gbsd_pkg::VNUM_W-1:0]   last_vertex;
  logic                          connected;

  modport source (
    output valid, output status, output bond_count, output degree_a, output degree_b,
    output count_at_degree_a, output count_at_degree_b, output graph_key,
    output last_vertex, output connected, input ready
  );
  modport sink (
    input valid, input status, input bond_count, input degree_a, input degree_b,
    input count_at_degree_a, input count_at_degree_b, input graph_key,
    input last_vertex, input connected, output ready
  );
endinterface

// ----- rtl/core/gbsd_store.sv -----
// ----------------------------------------------------------------------------
// gbsd_store
// Adjacency matrix, degrees, degree histogram and bond count, with the
// bond checks, the update and the report lookups.
// ----------------------------------------------------------------------------
module gbsd_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gbsd_pkg::VNUM_W-1:0] cfg_wdata,
  input  gbsd_pkg::store_ctl_t        ctl,
  output gbsd_pkg::adj_t              adj,
  output gbsd_pkg::report_t           rep
);

  logic [gbsd_pkg::VNUM_W-1:0]                                  vcount;
  logic [gbsd_pkg::MAX_VERTICES-1:0][gbsd_pkg::DEG_W-1:0]       deg;
  logic [gbsd_pkg::MAX_VERTICES-1:0][gbsd_pkg::CNT_W-1:0]       hist;
  logic [gbsd_pkg::BOND_W-1:0]                                  bonds;
  gbsd_pkg::status_t                                            status;

  logic [gbsd_pkg::VNUM_W-1:0]                            vcount_cfg;
  logic [gbsd_pkg::VIDX_W-1:0]                            ia, ib;
  logic                                                   va, vb, present;
  logic                                                   do_flip, do_clear;
  gbsd_pkg::status_t                                      chk_status;
  logic [gbsd_pkg::DEG_W-1:0]                             dega, degb, nda, ndb;
  logic [gbsd_pkg::MAX_VERTICES-1:0][gbsd_pkg::CNT_W-1:0] hist_next;
  logic [gbsd_pkg::MAX_VERTICES-1:0][gbsd_pkg::DEG_W-1:0] deg_next;
  gbsd_pkg::adj_t                                         adj_next;
  logic [gbsd_pkg::KEY_W-1:0]                             key_full;
  logic [gbsd_pkg::PROD_W-1:0]                            prod;
  logic [gbsd_pkg::PAIR_W-1:0]                            pairs;

  always_comb begin
    if (cfg_wdata < gbsd_pkg::VCOUNT_MIN) begin
      vcount_cfg = gbsd_pkg::VCOUNT_MIN;
    end else if (cfg_wdata > gbsd_pkg::VCOUNT_RESET) begin
      vcount_cfg = gbsd_pkg::VCOUNT_RESET;
    end else begin
      vcount_cfg = cfg_wdata;
    end
  end

  assign ia      = gbsd_pkg::VIDX_W'(ctl.vertex_a - gbsd_pkg::VNUM_W'(1));
  assign ib      = gbsd_pkg::VIDX_W'(ctl.vertex_b - gbsd_pkg::VNUM_W'(1));
  assign va      = (ctl.vertex_a != '0) && (ctl.vertex_a <= vcount);
  assign vb      = (ctl.vertex_b != '0) && (ctl.vertex_b <= vcount);
  assign present = adj[ia][ib];

  // check order: same vertex, range, presence
  always_comb begin
    chk_status = gbsd_pkg::ST_OK;
    do_flip    = 1'b0;
    do_clear   = 1'b0;
    case (ctl.func)
      gbsd_pkg::FN_ADD, gbsd_pkg::FN_REMOVE: begin
        if (ctl.vertex_a == ctl.vertex_b) begin
          chk_status = gbsd_pkg::ST_SAME;
        end else if (!va || !vb) begin
          chk_status = gbsd_pkg::ST_RANGE;
        end else if (ctl.func == gbsd_pkg::FN_ADD && present) begin
          chk_status = gbsd_pkg::ST_PRESENT;
        end else if (ctl.func == gbsd_pkg::FN_REMOVE && !present) begin
          chk_status = gbsd_pkg::ST_ABSENT;
        end else begin
          do_flip = 1'b1;
        end
      end
      gbsd_pkg::FN_CLEAR: do_clear = 1'b1;
      default: ;
    endcase
  end

  assign dega = deg[ia];
  assign degb = deg[ib];
  assign nda  = (ctl.func == gbsd_pkg::FN_ADD) ? dega + 1'b1 : dega - 1'b1;
  assign ndb  = (ctl.func == gbsd_pkg::FN_ADD) ? degb + 1'b1 : degb - 1'b1;

  // both end points move one histogram slot; the net change per entry adds up
  always_comb begin
    for (int k = 0; k < gbsd_pkg::MAX_VERTICES; k++) begin
      hist_next[k] = hist[k]
                   - gbsd_pkg::CNT_W'(gbsd_pkg::DEG_W'(k) == dega)
                   - gbsd_pkg::CNT_W'(gbsd_pkg::DEG_W'(k) == degb)
                   + gbsd_pkg::CNT_W'(gbsd_pkg::DEG_W'(k) == nda)
                   + gbsd_pkg::CNT_W'(gbsd_pkg::DEG_W'(k) == ndb);
    end
  end

  always_comb begin
    adj_next         = adj;
    deg_next         = deg;
    adj_next[ia][ib] = ~adj[ia][ib];
    adj_next[ib][ia] = ~adj[ib][ia];
    deg_next[ia]     = nda;
    deg_next[ib]     = ndb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount  <= gbsd_pkg::VCOUNT_RESET;
      adj     <= '0;
      deg     <= '0;
      hist    <= {{((gbsd_pkg::MAX_VERTICES - 1) * gbsd_pkg::CNT_W){1'b0}},
                  gbsd_pkg::VCOUNT_RESET};
      bonds   <= '0;
      status  <= gbsd_pkg::ST_OK;
    end else if (cfg_we) begin
      vcount  <= vcount_cfg;
      adj     <= '0;
      deg     <= '0;
      hist    <= {{((gbsd_pkg::MAX_VERTICES - 1) * gbsd_pkg::CNT_W){1'b0}}, vcount_cfg};
      bonds   <= '0;
    end else if (ctl.apply) begin
      status <= chk_status;
      if (do_clear) begin
        adj     <= '0;
        deg     <= '0;
        hist    <= {{((gbsd_pkg::MAX_VERTICES - 1) * gbsd_pkg::CNT_W){1'b0}}, vcount};
        bonds   <= '0;
      end else if (do_flip) begin
        adj         <= adj_next;
        deg         <= deg_next;
        hist        <= hist_next;
        bonds       <= (ctl.func == gbsd_pkg::FN_ADD) ? bonds + 1'b1 : bonds - 1'b1;
      end
    end
  end

  // key: pairs (1,2),(1,3),(2,3),(1,4).. from the top bit of the full key,
  // then right aligned to the pair count of the current vertex count
  always_comb begin
    int p;
    p        = 0;
    key_full = '0;
    for (int col = 1; col < gbsd_pkg::MAX_VERTICES; col++) begin
      for (int row = 0; row < col; row++) begin
        key_full[gbsd_pkg::KEY_W-1-p] = adj[row][col];
        p++;
      end
    end
  end

  assign prod  = gbsd_pkg::PROD_W'(vcount) * gbsd_pkg::PROD_W'(vcount - gbsd_pkg::VNUM_W'(1));
  assign pairs = gbsd_pkg::PAIR_W'(prod >> 1);

  always_comb begin
    rep                   = '0;
    rep.status            = status;
    rep.bond_count        = bonds;
    rep.degree_a          = va ? deg[ia] : '0;
    rep.degree_b          = vb ? deg[ib] : '0;
    rep.count_at_degree_a = hist[rep.degree_a];
    rep.count_at_degree_b = hist[rep.degree_b];
    rep.graph_key         = key_full >> (gbsd_pkg::PAIR_W'(gbsd_pkg::KEY_W) - pairs);
    for (int v = 0; v < gbsd_pkg::MAX_VERTICES; v++) begin
      if (adj[v] != '0) begin
        rep.last_vertex = gbsd_pkg::VNUM_W'(v + 1);
      end
    end
  end

  a_bond_limit: assert property (@(posedge clk) disable iff (rst)
    bonds <= gbsd_pkg::BOND_W'(gbsd_pkg::KEY_W))
    else $error("bond count beyond pair count");

  a_symmetric: assert property (@(posedge clk) disable iff (rst)
    ctl.apply && !cfg_we |=> adj[$past(ia)][$past(ib)] == adj[$past(ib)][$past(ia)])
    else $error("adjacency lost symmetry");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> bonds == '0 && hist[0] == vcount && adj == '0)
    else $error("config write did not clear graph");

endmodule

// ----- rtl/core/gbsd_walk.sv -----
// ----------------------------------------------------------------------------
// gbsd_walk
// Reachability from vertex 1: one shared OR unit widens the reached set by
// one hop per cycle while busy.
// ----------------------------------------------------------------------------
module gbsd_walk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  gbsd_pkg::adj_t              adj,
  input  logic [gbsd_pkg::VNUM_W-1:0] last_vertex,
  output logic                        busy,
  output logic                        connected
);

  logic [gbsd_pkg::MAX_VERTICES-1:0] reach, expand, need;
  logic [gbsd_pkg::VIDX_W-1:0]       cnt;

  always_comb begin
    expand = '0;
    for (int v = 0; v < gbsd_pkg::MAX_VERTICES; v++) begin
      if (reach[v]) begin
        expand = expand | adj[v];
      end
    end
  end

  always_comb begin
    for (int v = 0; v < gbsd_pkg::MAX_VERTICES; v++) begin
      need[v] = gbsd_pkg::VNUM_W'(v) < last_vertex;
    end
  end

  // empty graph: need is zero, so connected
  assign connected = (reach & need) == need;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      reach <= gbsd_pkg::MAX_VERTICES'(1);
    end else if (busy) begin
      reach <= reach | expand;
      cnt   <= cnt + 1'b1;
      if (cnt == gbsd_pkg::VIDX_W'(gbsd_pkg::MAX_VERTICES - 2)) begin
        busy <= 1'b0;
      end
    end
  end

  a_root: assert property (@(posedge clk) disable iff (rst)
    busy |-> reach[0])
    else $error("vertex 1 missing from reached set");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> (reach & $past(reach)) == $past(reach))
    else $error("reached set shrank");

  a_len: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == '0)
    else $error("walk did not restart");

endmodule

// ----- rtl/core/graph_bond_store_degree_tracker_top.sv -----
// ----------------------------------------------------------------------------
// graph_bond_store_degree_tracker_top
// Undirected graph store with degrees, degree histogram, bond count,
// upper-triangle key, highest used vertex and connectivity report.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  cmd     | in  | valid/ready       | func, vertex_a, vertex_b
//  rpt     | out | valid/ready       | status .. connected (one per cmd)
//  cfg     | in  | cfg_we, no ready  | vertex_count (clamped to 2..8)
//
//  A command runs accept, apply, 7 walk steps through the shared reach unit
//  (one hop per cycle), walk done and report load before the next accept.
//  The report word is registered in the output register at report load.
//  cmd.ready is high only in idle; a waiting report blocks only its load.
//  Synchronous reset or a cfg write clears the graph.
// ----------------------------------------------------------------------------
module graph_bond_store_degree_tracker_top (
  input  logic                        clk,
  input  logic                        rst,
  gbsd_cmd_if.sink                    cmd,
  gbsd_rpt_if.source                  rpt,
  input  logic                        cfg_we,
  input  logic [gbsd_pkg::VNUM_W-1:0] cfg_wdata
);

  gbsd_pkg::state_t     state, state_next;
  gbsd_pkg::store_ctl_t ctl;
  gbsd_pkg::report_t    rep;
  gbsd_pkg::adj_t       adj;
  gbsd_pkg::func_t      func;
  logic [gbsd_pkg::VNUM_W-1:0] vertex_a, vertex_b;
  logic                 walk_start, walk_busy, connected, load;

  always_comb begin
    state_next = state;
    case (state)
      gbsd_pkg::S_IDLE:   if (cmd.valid) state_next = gbsd_pkg::S_APPLY;
      gbsd_pkg::S_APPLY:  state_next = gbsd_pkg::S_WALK;
      gbsd_pkg::S_WALK:   if (!walk_busy) state_next = gbsd_pkg::S_REPORT;
      gbsd_pkg::S_REPORT: if (!rpt.valid || rpt.ready) state_next = gbsd_pkg::S_IDLE;
      default:            state_next = gbsd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready  = 1'b0;
    walk_start = 1'b0;
    load       = 1'b0;
    case (state)
      gbsd_pkg::S_IDLE:   cmd.ready  = 1'b1;
      gbsd_pkg::S_APPLY:  walk_start = 1'b1;
      gbsd_pkg::S_REPORT: load       = !rpt.valid || rpt.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      func     <= gbsd_pkg::func_t'(cmd.func);
      vertex_a <= cmd.vertex_a;
      vertex_b <= cmd.vertex_b;
    end
  end

  assign ctl.apply    = walk_start;
  assign ctl.func     = func;
  assign ctl.vertex_a = vertex_a;
  assign ctl.vertex_b = vertex_b;

  gbsd_store u_store (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .adj       (adj),
    .rep       (rep)
  );

  gbsd_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .start       (walk_start),
    .adj         (adj),
    .last_vertex (rep.last_vertex),
    .busy        (walk_busy),
    .connected   (connected)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt.valid <= 1'b0;
    end else if (load) begin
      rpt.valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rpt.status            <= rep.status;
      rpt.bond_count        <= rep.bond_count;
      rpt.degree_a          <= rep.degree_a;
      rpt.degree_b          <= rep.degree_b;
      rpt.count_at_degree_a <= rep.count_at_degree_a;
      rpt.count_at_degree_b <= rep.count_at_degree_b;
      rpt.graph_key         <= rep.graph_key;
      rpt.last_vertex       <= rep.last_vertex;
      rpt.connected         <= connected;
    end
  end

endmodule

// ----- tb/sv/tb_graph_bond_store_degree_tracker_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graph_bond_store_degree_tracker_top
// Self-checking bench for the graph bond store. A local copy of the graph,
// the degrees, the degree histogram and the bond count predicts every report
// word. Named tests cover the error checks, clear and no-op commands, the
// vertex count limits, a complete graph, and random traffic. Random idling
// is applied on both channels.
// ----------------------------------------------------------------------------
module tb_graph_bond_store_degree_tracker_top;

  typedef struct {
    gbsd_pkg::status_t            status;
    logic [gbsd_pkg::BOND_W-1:0]  bond_count;
    logic [gbsd_pkg::DEG_W-1:0]   degree_a;
    logic [gbsd_pkg::DEG_W-1:0]   degree_b;
    logic [gbsd_pkg::CNT_W-1:0]   count_at_degree_a;
    logic [gbsd_pkg::CNT_W-1:0]   count_at_degree_b;
    logic [gbsd_pkg::KEY_W-1:0]   graph_key;
    logic [gbsd_pkg::VNUM_W-1:0]  last_vertex;
    logic                         connected;
  } graph_report_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [gbsd_pkg::VNUM_W-1:0] cfg_wdata;

  gbsd_cmd_if cmd_ch ();
  gbsd_rpt_if rpt_ch ();

  graph_bond_store_degree_tracker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rpt       (rpt_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow graph
  logic [gbsd_pkg::MAX_VERTICES-1:0] bond_rows [gbsd_pkg::MAX_VERTICES];
  logic [gbsd_pkg::DEG_W-1:0]        vtx_degree [gbsd_pkg::MAX_VERTICES];
  logic [gbsd_pkg::CNT_W-1:0]        degree_hist [gbsd_pkg::MAX_VERTICES];
  logic [gbsd_pkg::BOND_W-1:0]       bonds_now;
  int                                vtx_count;

  graph_report_t expected_reports [$];

  int src_gap_pct;
  int snk_stall_pct;
  int mismatches;
  int words_checked;
  int cmds_sent;
  int cfg_writes;
  int split_graphs;
  int status_seen [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void clear_shadow_graph();
    for (int i = 0; i < gbsd_pkg::MAX_VERTICES; i++) begin
      bond_rows[i]   = '0;
      vtx_degree[i]  = '0;
      degree_hist[i] = '0;
    end
    degree_hist[0] = gbsd_pkg::CNT_W'(vtx_count);
    bonds_now      = '0;
  endfunction

  function automatic void set_shadow_count(logic [gbsd_pkg::VNUM_W-1:0] value);
    vtx_count = (value < gbsd_pkg::VCOUNT_MIN) ? int'(gbsd_pkg::VCOUNT_MIN) :
                (value > gbsd_pkg::MAX_VERTICES) ? gbsd_pkg::MAX_VERTICES : int'(value);
    clear_shadow_graph();
  endfunction

  function automatic void shift_vertex(int v, bit up);
    logic [gbsd_pkg::DEG_W-1:0] d;
    logic [gbsd_pkg::DEG_W-1:0] nd;
    d  = vtx_degree[v-1];
    nd = up ? d + 1'b1 : d - 1'b1;
    degree_hist[d]  = degree_hist[d] - 1'b1;
    degree_hist[nd] = degree_hist[nd] + 1'b1;
    vtx_degree[v-1] = nd;
  endfunction

  function automatic graph_report_t apply_bond_op(gbsd_pkg::func_t f,
                                                  logic [gbsd_pkg::VNUM_W-1:0] a,
                                                  logic [gbsd_pkg::VNUM_W-1:0] b);
    graph_report_t                     w;
    bit                                a_ok;
    bit                                b_ok;
    bit                                present;
    int                                ia;
    int                                ib;
    int                                need;
    logic [gbsd_pkg::MAX_VERTICES-1:0] reach;
    ia   = int'(a);
    ib   = int'(b);
    a_ok = (ia >= 1) && (ia <= vtx_count);
    b_ok = (ib >= 1) && (ib <= vtx_count);
    w.status = gbsd_pkg::ST_OK;
    if (f == gbsd_pkg::FN_CLEAR) begin
      clear_shadow_graph();
    end else if (f == gbsd_pkg::FN_ADD || f == gbsd_pkg::FN_REMOVE) begin
      if (a == b) begin
        w.status = gbsd_pkg::ST_SAME;
      end else if (!a_ok || !b_ok) begin
        w.status = gbsd_pkg::ST_RANGE;
      end else begin
        present = bond_rows[ia-1][ib-1];
        if (f == gbsd_pkg::FN_ADD && present) begin
          w.status = gbsd_pkg::ST_PRESENT;
        end else if (f == gbsd_pkg::FN_REMOVE && !present) begin
          w.status = gbsd_pkg::ST_ABSENT;
        end else begin
          bond_rows[ia-1][ib-1] = ~bond_rows[ia-1][ib-1];
          bond_rows[ib-1][ia-1] = ~bond_rows[ib-1][ia-1];
          shift_vertex(ia, f == gbsd_pkg::FN_ADD);
          shift_vertex(ib, f == gbsd_pkg::FN_ADD);
          bonds_now = (f == gbsd_pkg::FN_ADD) ? bonds_now + 1'b1 : bonds_now - 1'b1;
        end
      end
    end
    w.bond_count        = bonds_now;
    w.degree_a          = a_ok ? vtx_degree[ia-1] : '0;
    w.degree_b          = b_ok ? vtx_degree[ib-1] : '0;
    w.count_at_degree_a = degree_hist[w.degree_a];
    w.count_at_degree_b = degree_hist[w.degree_b];
    // upper triangle column by column, pair (1,2) ends up as the top used bit
    w.graph_key = '0;
    for (int col = 2; col <= vtx_count; col++)
      for (int row = 1; row < col; row++)
        w.graph_key = {w.graph_key[gbsd_pkg::KEY_W-2:0], bond_rows[row-1][col-1]};
    w.last_vertex = '0;
    for (int v = 1; v <= vtx_count; v++)
      if (bond_rows[v-1] != '0) w.last_vertex = gbsd_pkg::VNUM_W'(v);
    reach = 'b1;
    for (int s = 0; s < gbsd_pkg::MAX_VERTICES; s++)
      for (int v = 0; v < vtx_count; v++)
        if (reach[v]) reach = reach | bond_rows[v];
    need = (1 << w.last_vertex) - 1;
    w.connected = ((int'(reach) & need) == need);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Report checking
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  task automatic check_report_word();
    graph_report_t e;
    if (expected_reports.size() == 0) begin
      mismatches++;
      $display("%0t: report word with nothing expected, actual status %0h key %0h",
               $time, rpt_ch.status, rpt_ch.graph_key);
      return;
    end
    e = expected_reports.pop_front();
    words_checked++;
    status_seen[e.status]++;
    if (!e.connected) split_graphs++;
    compare_field("status", e.status, rpt_ch.status);
    compare_field("bond_count", e.bond_count, rpt_ch.bond_count);
    compare_field("degree_a", e.degree_a, rpt_ch.degree_a);
    compare_field("degree_b", e.degree_b, rpt_ch.degree_b);
    compare_field("count_at_degree_a", e.count_at_degree_a, rpt_ch.count_at_degree_a);
    compare_field("count_at_degree_b", e.count_at_degree_b, rpt_ch.count_at_degree_b);
    compare_field("graph_key", e.graph_key, rpt_ch.graph_key);
    compare_field("last_vertex", e.last_vertex, rpt_ch.last_vertex);
    compare_field("connected", e.connected, rpt_ch.connected);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rpt_ch.ready <= 1'b0;
    end else begin
      if (rpt_ch.valid && rpt_ch.ready) check_report_word();
      rpt_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // valid stays high after a word; it drops only on a gap or a drain
  task automatic send_bond_op(gbsd_pkg::func_t f, logic [gbsd_pkg::VNUM_W-1:0] a,
                              logic [gbsd_pkg::VNUM_W-1:0] b);
    graph_report_t w;
    if ($urandom_range(99) < src_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.func     <= f;
    cmd_ch.vertex_a <= a;
    cmd_ch.vertex_b <= b;
    do @(posedge clk); while (!cmd_ch.ready);
    cmds_sent++;
    w = apply_bond_op(f, a, b);
    expected_reports.insert(expected_reports.size(), w);
  endtask

  task automatic drain_reports();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic write_vertex_count(logic [gbsd_pkg::VNUM_W-1:0] value);
    drain_reports();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
    set_shadow_count(value);
  endtask

  function automatic logic [gbsd_pkg::VNUM_W-1:0] pick_vertex();
    return gbsd_pkg::VNUM_W'($urandom_range(vtx_count, 1));
  endfunction

  // mostly legal bond edits on a random pair, some clears, some raw noise
  task automatic send_random_op();
    int                          r;
    logic [gbsd_pkg::VNUM_W-1:0] a;
    logic [gbsd_pkg::VNUM_W-1:0] b;
    r = $urandom_range(99);
    if (r < 85) begin
      a = pick_vertex();
      b = gbsd_pkg::VNUM_W'($urandom_range(vtx_count - 1, 1));
      if (b >= a) b = b + 1'b1;
      send_bond_op(($urandom_range(99) < 55) ? gbsd_pkg::FN_ADD : gbsd_pkg::FN_REMOVE,
                   a, b);
    end else if (r < 88) begin
      send_bond_op(gbsd_pkg::FN_CLEAR, gbsd_pkg::VNUM_W'($urandom_range(15)),
                   gbsd_pkg::VNUM_W'($urandom_range(15)));
    end else begin
      send_bond_op(gbsd_pkg::func_t'($urandom_range(3)),
                   gbsd_pkg::VNUM_W'($urandom_range(15)),
                   gbsd_pkg::VNUM_W'($urandom_range(15)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_checks_and_ops();
    send_bond_op(gbsd_pkg::FN_NOP, 4'd0, 4'd15);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd1, 4'd2);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd2, 4'd1);     // already present
    send_bond_op(gbsd_pkg::FN_ADD, 4'd3, 4'd3);     // same vertex
    send_bond_op(gbsd_pkg::FN_REMOVE, 4'd0, 4'd0);  // same vertex wins over range
    send_bond_op(gbsd_pkg::FN_ADD, 4'd0, 4'd5);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd5, 4'd9);
    send_bond_op(gbsd_pkg::FN_REMOVE, 4'd15, 4'd1);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd8, 4'd7);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd1, 4'd8);
    send_bond_op(gbsd_pkg::FN_NOP, 4'd1, 4'd8);
    send_bond_op(gbsd_pkg::FN_REMOVE, 4'd1, 4'd2);
    send_bond_op(gbsd_pkg::FN_REMOVE, 4'd2, 4'd1);  // absent
    send_bond_op(gbsd_pkg::FN_ADD, 4'd3, 4'd4);     // split graph
    send_bond_op(gbsd_pkg::FN_CLEAR, 4'd7, 4'd7);
    send_bond_op(gbsd_pkg::FN_CLEAR, 4'd15, 4'd0);
    send_bond_op(gbsd_pkg::FN_REMOVE, 4'd4, 4'd6);
  endtask

  task automatic test_vertex_count_limits();
    write_vertex_count(4'd0);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd1, 4'd2);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd1, 4'd3);
    send_bond_op(gbsd_pkg::FN_REMOVE, 4'd2, 4'd1);
    write_vertex_count(4'd1);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd2, 4'd1);
    send_bond_op(gbsd_pkg::FN_NOP, 4'd2, 4'd3);
    write_vertex_count(4'd15);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd8, 4'd9);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd6, 4'd8);
    write_vertex_count(4'd9);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd3, 4'd8);
    write_vertex_count(4'd3);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd2, 4'd3);
    send_bond_op(gbsd_pkg::FN_ADD, 4'd1, 4'd4);
  endtask

  task automatic test_complete_graph();
    write_vertex_count(4'd8);
    for (int c = 2; c <= gbsd_pkg::MAX_VERTICES; c++)
      for (int r = 1; r < c; r++)
        send_bond_op(gbsd_pkg::FN_ADD, gbsd_pkg::VNUM_W'(c), gbsd_pkg::VNUM_W'(r));
    send_bond_op(gbsd_pkg::FN_ADD, 4'd4, 4'd5);
    send_bond_op(gbsd_pkg::FN_NOP, 4'd8, 4'd1);
    for (int c = gbsd_pkg::MAX_VERTICES; c >= 2; c--)
      for (int r = 1; r < c; r++)
        send_bond_op(gbsd_pkg::FN_REMOVE, gbsd_pkg::VNUM_W'(r), gbsd_pkg::VNUM_W'(c));
  endtask

  task automatic test_random_traffic(int n_words);
    for (int i = 0; i < n_words; i++) begin
      if (i % 60 == 0) write_vertex_count(gbsd_pkg::VNUM_W'($urandom_range(15)));
      send_random_op();
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.func     = gbsd_pkg::FN_NOP;
    cmd_ch.vertex_a = '0;
    cmd_ch.vertex_b = '0;
    src_gap_pct     = 22;
    snk_stall_pct   = 77;
    mismatches      = 0;
    words_checked   = 0;
    cmds_sent       = 0;
    cfg_writes      = 0;
    split_graphs    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    set_shadow_count(gbsd_pkg::VCOUNT_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_checks_and_ops();
    test_vertex_count_limits();
    test_complete_graph();
    test_random_traffic(240);

    drain_reports();
    src_gap_pct   = 77;
    snk_stall_pct = 22;
    test_random_traffic(240);

    drain_reports();
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    test_random_traffic(240);

    drain_reports();
    repeat (20) @(posedge clk);
    compare_field("words left over", 0, expected_reports.size());
    $display("Checked %0d report words for %0d commands over %0d vertex count writes.",
             words_checked, cmds_sent, cfg_writes);
    $display("Status ok/same/range/present/absent: %0d/%0d/%0d/%0d/%0d, split graphs: %0d",
             status_seen[gbsd_pkg::ST_OK], status_seen[gbsd_pkg::ST_SAME],
             status_seen[gbsd_pkg::ST_RANGE], status_seen[gbsd_pkg::ST_PRESENT],
             status_seen[gbsd_pkg::ST_ABSENT], split_graphs);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
